### rtl/nig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nig_pkg
// Shared types and constants of the normal-inverse-gamma update core.
// ----------------------------------------------------------------------------
package nig_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_PRIOR_MEAN     = 2'd0;
    localparam logic [1:0] CFG_PRIOR_SHAPE    = 2'd1;
    localparam logic [1:0] CFG_PRIOR_RATE     = 2'd2;
    localparam logic [1:0] CFG_PRIOR_STRENGTH = 2'd3;

    localparam logic [23:0] RST_PRIOR_MEAN     = 24'd0;
    localparam logic [31:0] RST_PRIOR_SHAPE    = 32'd65536;
    localparam logic [31:0] RST_PRIOR_RATE     = 32'd65536;
    localparam logic [31:0] RST_PRIOR_STRENGTH = 32'd65536;

    localparam logic [23:0] MEAN_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] MEAN_NEG_MIN = 24'h800000;
    localparam logic [47:0] RATE_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] U32_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_ACC,
        S_PREP,
        S_PREP2,
        S_GO,
        S_WAIT,
        S_FIN,
        S_EMIT
    } state_t;

    // finalize steps, in issue order
    typedef enum logic [2:0] {
        ST_MEAN,    // |num| / den
        ST_SQS,     // |sum|^2
        ST_SSDIV,   // sum^2 / n
        ST_SQD,     // |D|^2
        ST_MULLQ,   // D^2 * lambda0
        ST_DIVN,    // / n
        ST_DIVDEN   // / den
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  prep;
        logic  prep2;
        logic  go;
        logic  save;
        step_t step;
        logic  finish;
        logic  load;
    } nig_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic done;
        logic out_free;
    } nig_stat_t;

endpackage

### rtl/nig_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nig_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module nig_mul #(
    parameter int AW = 102,
    parameter int BW = 35
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [AW-1:0] p
);
    localparam int CNTW = $clog2(BW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [AW-1:0]   a_reg, a_next;
    logic [BW-1:0]   b_reg, b_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(BW);
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### rtl/nig_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nig_div
// Restoring unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module nig_div #(
    parameter int NW = 102,
    parameter int DW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic          done,
    output logic [NW-1:0] q
);
    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [DW:0]     rem_sh;
    logic            ge;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign ge     = (rem_sh >= {1'b0, d_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            rem_next  = '0;
            q_next    = n;
            d_next    = d;
        end else if (busy_reg) begin
            rem_next = ge ? DW'(rem_sh - {1'b0, d_reg}) : rem_sh[DW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

### rtl/nig_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nig_datapath
// Prior registers, accumulators, finalize arithmetic and result register.
// ----------------------------------------------------------------------------
module nig_datapath #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  nig_pkg::nig_cmd_t   cmd,
    output nig_pkg::nig_stat_t  stat,
    input  logic signed [23:0]  s_sample,
    input  logic                s_has_sample,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [23:0]  m_post_mean,
    output logic [31:0]         m_post_shape,
    output logic [47:0]         m_post_rate,
    output logic [31:0]         m_post_strength,
    output logic [10:0]         m_sample_count,
    output logic                m_overflow
);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CW + 24;
    localparam int SQ_W  = CW + 46;
    localparam int DW    = CW + 24;
    localparam int BW    = (DW > 32) ? DW : 32;
    localparam int MW    = 2 * DW + 32;
    localparam int DENW  = ((CW + 16) > 32 ? (CW + 16) : 32) + 1;
    localparam int NUMW  = ((CW + 39) > 55 ? (CW + 39) : 55) + 2;
    localparam int DFW   = CW + 25;

    // prior registers
    logic signed [23:0] mu0_reg;
    logic [31:0]        alpha0_reg, beta0_reg, lambda0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu0_reg     <= nig_pkg::RST_PRIOR_MEAN;
            alpha0_reg  <= nig_pkg::RST_PRIOR_SHAPE;
            beta0_reg   <= nig_pkg::RST_PRIOR_RATE;
            lambda0_reg <= nig_pkg::RST_PRIOR_STRENGTH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nig_pkg::CFG_PRIOR_MEAN:     mu0_reg     <= cfg_data[23:0];
                nig_pkg::CFG_PRIOR_SHAPE:    alpha0_reg  <= cfg_data;
                nig_pkg::CFG_PRIOR_RATE:     beta0_reg   <= cfg_data;
                nig_pkg::CFG_PRIOR_STRENGTH: lambda0_reg <= cfg_data;
            endcase
        end
    end

    // accumulators
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    drop_reg, drop_next;
    logic [23:0]             s_abs;
    logic [47:0]             s_sq;

    assign s_abs = s_sample[23] ? 24'(-s_sample) : 24'(s_sample);
    assign s_sq  = s_abs * s_abs;

    always_comb begin
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (cmd.load) begin
            sum_next  = '0;
            sq_next   = '0;
            cnt_next  = '0;
            drop_next = 1'b0;
        end else if (cmd.accept && s_has_sample) begin
            if (cnt_reg < CW'(MAX_SAMPLES)) begin
                sum_next = sum_reg + SUM_W'(s_sample);
                sq_next  = sq_reg + SQ_W'(s_sq);
                cnt_next = cnt_reg + CW'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

    // finalize operands
    logic [DENW-1:0]        den_reg;
    logic [33:0]            shape_reg, str_reg;
    logic [55:0]            lqmq_reg;
    logic                   mq_neg_reg;
    logic signed [DFW-1:0]  nmq_reg;
    logic [DW-1:0]          us_reg, ud_reg;
    logic [NUMW-1:0]        num_reg;
    logic [MW-1:0]          meanq_reg, tmp_reg;
    logic [SQ_W-1:0]        ss_reg;

    logic [23:0]            mq_abs;
    logic [NUMW-1:0]        num_t1, num_t2, num_abs;
    logic signed [DFW-1:0]  d_val;

    assign mq_abs  = mu0_reg[23] ? 24'(-mu0_reg) : 24'(mu0_reg);
    assign num_t1  = mq_neg_reg ? (NUMW'(0) - NUMW'(lqmq_reg)) : NUMW'(lqmq_reg);
    assign num_t2  = NUMW'(sum_reg) << 16;
    assign num_abs = num_reg[NUMW-1] ? (NUMW'(0) - num_reg) : num_reg;
    assign d_val   = DFW'(sum_reg) - nmq_reg;

    // shared iterative units
    logic          is_mul;
    logic [MW-1:0] mul_a, mul_p, div_n, div_q;
    logic [BW-1:0] mul_b;
    logic [DENW-1:0] div_d;
    logic          mul_done, div_done;

    assign is_mul = (cmd.step == nig_pkg::ST_SQS) || (cmd.step == nig_pkg::ST_SQD)
                 || (cmd.step == nig_pkg::ST_MULLQ);

    always_comb begin
        mul_a = tmp_reg;
        mul_b = BW'(lambda0_reg);
        div_n = tmp_reg;
        div_d = DENW'(cnt_reg);
        unique case (cmd.step)
            nig_pkg::ST_MEAN: begin
                div_n = MW'(num_abs);
                div_d = den_reg;
            end
            nig_pkg::ST_SQS: begin
                mul_a = MW'(us_reg);
                mul_b = BW'(us_reg);
            end
            nig_pkg::ST_SQD: begin
                mul_a = MW'(ud_reg);
                mul_b = BW'(ud_reg);
            end
            nig_pkg::ST_DIVDEN: div_d = den_reg;
            default: ;
        endcase
    end

    nig_mul #(.AW(MW), .BW(BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.go && is_mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    nig_div #(.NW(MW), .DW(DENW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.go && !is_mul),
        .n       (div_n),
        .d       (div_d),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            den_reg    <= DENW'({cnt_reg, 16'b0}) + DENW'(lambda0_reg);
            shape_reg  <= 34'(alpha0_reg) + (34'(cnt_reg) << 15);
            str_reg    <= 34'(lambda0_reg) + (34'(cnt_reg) << 16);
            lqmq_reg   <= 56'(lambda0_reg) * 56'(mq_abs);
            mq_neg_reg <= mu0_reg[23];
            nmq_reg    <= $signed({1'b0, cnt_reg}) * mu0_reg;
            us_reg     <= sum_reg[SUM_W-1] ? DW'(-sum_reg) : DW'(sum_reg);
        end
        if (cmd.prep2) begin
            num_reg <= num_t1 + num_t2;
            ud_reg  <= d_val[DFW-1] ? DW'(-d_val) : DW'(d_val);
        end
        if (cmd.save) begin
            unique case (cmd.step)
                nig_pkg::ST_MEAN:  meanq_reg <= div_q;
                nig_pkg::ST_SSDIV: ss_reg <= (div_q > MW'(sq_reg)) ? '0
                                           : SQ_W'(MW'(sq_reg) - div_q);
                nig_pkg::ST_SQS, nig_pkg::ST_SQD, nig_pkg::ST_MULLQ: tmp_reg <= mul_p;
                nig_pkg::ST_DIVN, nig_pkg::ST_DIVDEN: tmp_reg <= div_q;
                default: ;
            endcase
        end
    end

    // final saturation
    logic [23:0] r_mean_reg;
    logic [31:0] r_shape_reg, r_str_reg;
    logic [47:0] r_rate_reg;
    logic        r_sat_reg;

    logic [23:0] f_mean;
    logic        f_mean_sat, f_shape_sat, f_str_sat, f_rate_sat;
    logic [MW-1:0] t3;
    logic [49:0] rate_sum;
    logic [47:0] f_rate;

    assign t3          = tmp_reg >> 17;
    assign rate_sum    = 50'(beta0_reg) + 50'(ss_reg >> 17) + 50'(t3[47:0]);
    assign f_shape_sat = (shape_reg > 34'(nig_pkg::U32_MAX));
    assign f_str_sat   = (str_reg > 34'(nig_pkg::U32_MAX));

    always_comb begin
        if (num_reg[NUMW-1]) begin
            f_mean_sat = (meanq_reg > MW'(nig_pkg::MEAN_NEG_MIN));
            f_mean     = f_mean_sat ? nig_pkg::MEAN_NEG_MIN : 24'(-meanq_reg[23:0]);
        end else begin
            f_mean_sat = (meanq_reg > MW'(nig_pkg::MEAN_POS_MAX));
            f_mean     = f_mean_sat ? nig_pkg::MEAN_POS_MAX : meanq_reg[23:0];
        end
        if ((t3 >> 48) != '0) begin
            f_rate_sat = 1'b1;
            f_rate     = nig_pkg::RATE_MAX;
        end else if (rate_sum > 50'(nig_pkg::RATE_MAX)) begin
            f_rate_sat = 1'b1;
            f_rate     = nig_pkg::RATE_MAX;
        end else begin
            f_rate_sat = 1'b0;
            f_rate     = rate_sum[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            r_mean_reg  <= f_mean;
            r_shape_reg <= f_shape_sat ? nig_pkg::U32_MAX : shape_reg[31:0];
            r_str_reg   <= f_str_sat ? nig_pkg::U32_MAX : str_reg[31:0];
            r_rate_reg  <= f_rate;
            r_sat_reg   <= f_mean_sat | f_shape_sat | f_str_sat | f_rate_sat;
        end
    end

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [23:0] om_mean_reg;
    logic [31:0] om_shape_reg, om_str_reg;
    logic [47:0] om_rate_reg;
    logic [10:0] om_cnt_reg;
    logic        om_ovf_reg;
    logic        cnt_zero;

    assign cnt_zero     = (cnt_reg == '0);
    assign m_valid_next = cmd.load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load) begin
            om_cnt_reg <= 11'(cnt_reg);
            if (cnt_zero) begin
                om_mean_reg  <= mu0_reg;
                om_shape_reg <= alpha0_reg;
                om_rate_reg  <= 48'(beta0_reg);
                om_str_reg   <= lambda0_reg;
                om_ovf_reg   <= drop_reg;
            end else begin
                om_mean_reg  <= r_mean_reg;
                om_shape_reg <= r_shape_reg;
                om_rate_reg  <= r_rate_reg;
                om_str_reg   <= r_str_reg;
                om_ovf_reg   <= drop_reg | r_sat_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_post_mean     = om_mean_reg;
    assign m_post_shape    = om_shape_reg;
    assign m_post_rate     = om_rate_reg;
    assign m_post_strength = om_str_reg;
    assign m_sample_count  = om_cnt_reg;
    assign m_overflow      = om_ovf_reg;

    assign stat.cnt_zero = cnt_zero;
    assign stat.done     = mul_done | div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

### rtl/nig_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nig_ctrl
// Sequencer: accumulate, then walk the finalize steps (none for an empty set), then load the result.
// ----------------------------------------------------------------------------
module nig_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    output logic                s_ready,
    input  nig_pkg::nig_stat_t  stat,
    output nig_pkg::nig_cmd_t   cmd
);
    nig_pkg::state_t state_reg, state_next;
    nig_pkg::step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nig_pkg::S_ACC;
            step_reg  <= nig_pkg::ST_MEAN;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            nig_pkg::S_ACC: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_last) begin
                    state_next = nig_pkg::S_PREP;
                end
            end
            nig_pkg::S_PREP: begin
                if (stat.cnt_zero) begin
                    state_next = nig_pkg::S_EMIT;
                end else begin
                    cmd.prep   = 1'b1;
                    state_next = nig_pkg::S_PREP2;
                end
            end
            nig_pkg::S_PREP2: begin
                cmd.prep2  = 1'b1;
                step_next  = nig_pkg::ST_MEAN;
                state_next = nig_pkg::S_GO;
            end
            nig_pkg::S_GO: begin
                cmd.go     = 1'b1;
                state_next = nig_pkg::S_WAIT;
            end
            nig_pkg::S_WAIT: begin
                if (stat.done) begin
                    cmd.save   = 1'b1;
                    state_next = nig_pkg::S_GO;
                    unique case (step_reg)
                        nig_pkg::ST_MEAN:  step_next = nig_pkg::ST_SQS;
                        nig_pkg::ST_SQS:   step_next = nig_pkg::ST_SSDIV;
                        nig_pkg::ST_SSDIV: step_next = nig_pkg::ST_SQD;
                        nig_pkg::ST_SQD:   step_next = nig_pkg::ST_MULLQ;
                        nig_pkg::ST_MULLQ: step_next = nig_pkg::ST_DIVN;
                        nig_pkg::ST_DIVN:  step_next = nig_pkg::ST_DIVDEN;
                        default:           state_next = nig_pkg::S_FIN;
                    endcase
                end
            end
            nig_pkg::S_FIN: begin
                cmd.finish = 1'b1;
                state_next = nig_pkg::S_EMIT;
            end
            nig_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = nig_pkg::S_ACC;
                end
            end
            default: state_next = nig_pkg::S_ACC;
        endcase
    end

endmodule

### rtl/normal_inverse_gamma_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_inverse_gamma_update_core
// Streaming normal-inverse-gamma posterior update in fixed point.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  --------+-----------------------------------------+---------------------------
//  s_      | s_valid/s_ready, sample, has_sample, last | one sample item
//  m_      | m_valid/m_ready, posterior fields         | one posterior per set
//  cfg_    | cfg_valid/cfg_ready, cfg_index, cfg_data  | one prior register write
//
//  Samples are taken one per cycle; each costs one 24x24 square and two adds.
//  The item marked last closes the set: the block then holds s_ready low while
//  a shared shift-add multiplier and a restoring divider (one bit per cycle)
//  work through the posterior on MW-bit operands, MW = 2*(CW+24)+32, with a
//  BW = max(CW+24, 32) bit multiplier operand, CW = clog2(MAX_SAMPLES+1).
//  An empty set skips the arithmetic. The result sits in an output register;
//  a stalled m_ready lets a new set be sampled, but holds its close, s_ready low.
//  Reset is synchronous, active low; priors return to their defaults.
// ----------------------------------------------------------------------------
module normal_inverse_gamma_update_core #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    // sample items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_sample,
    input  logic               s_has_sample,
    input  logic               s_last,
    // posterior items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_post_mean,
    output logic [31:0]        m_post_shape,
    output logic [47:0]        m_post_rate,
    output logic [31:0]        m_post_strength,
    output logic [10:0]        m_sample_count,
    output logic               m_overflow,
    // prior register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    nig_pkg::nig_cmd_t  cmd;
    nig_pkg::nig_stat_t stat;

    // priors are plain registers, a write always lands
    assign cfg_ready = 1'b1;

    nig_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nig_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_sample        (s_sample),
        .s_has_sample    (s_has_sample),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_post_mean     (m_post_mean),
        .m_post_shape    (m_post_shape),
        .m_post_rate     (m_post_rate),
        .m_post_strength (m_post_strength),
        .m_sample_count  (m_sample_count),
        .m_overflow      (m_overflow)
    );

endmodule

### test/tb_normal_inverse_gamma_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_inverse_gamma_update_core
// Self-checking bench for the streaming normal-inverse-gamma update core.
// A queue-fed driver streams sample items and a clocked monitor takes the
// posterior items. Every accepted item goes through a local predictor, and
// each posterior that comes out is compared with the oldest one predicted.
// The run covers default and extreme priors, empty sets, sets without a
// closing sample, overfilled sets and random sets, with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_normal_inverse_gamma_update_core;

    localparam int CAPACITY    = 1024;
    localparam int ITEM_TARGET = 1250;
    localparam int CLOSE_WAIT  = 700;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [23:0] sample;
        logic        has_sample;
        logic        last;
    } sample_item_t;

    typedef struct packed {
        logic [23:0] mean;
        logic [31:0] shape;
        logic [47:0] rate;
        logic [31:0] strength;
        logic [10:0] count;
        logic        ovf;
    } posterior_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [23:0] s_sample = '0;
    logic               s_has_sample = 1'b0;
    logic               s_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_post_mean;
    logic [31:0]        m_post_shape;
    logic [47:0]        m_post_rate;
    logic [31:0]        m_post_strength;
    logic [10:0]        m_sample_count;
    logic               m_overflow;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    normal_inverse_gamma_update_core #(.MAX_SAMPLES(CAPACITY)) i_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_sample, .s_has_sample, .s_last,
        .m_valid, .m_ready, .m_post_mean, .m_post_shape, .m_post_rate,
        .m_post_strength, .m_sample_count, .m_overflow,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // prior copy, mirrored on every accepted register write
    logic signed [23:0] mu0     = nig_pkg::RST_PRIOR_MEAN;
    logic [31:0]        alpha0  = nig_pkg::RST_PRIOR_SHAPE;
    logic [31:0]        beta0   = nig_pkg::RST_PRIOR_RATE;
    logic [31:0]        lambda0 = nig_pkg::RST_PRIOR_STRENGTH;

    // running statistics of the open set
    longint          set_sum = 0;
    longint unsigned set_sumsq = 0;
    int              set_count = 0;
    bit              set_dropped = 0;

    sample_item_t pending_items[$];
    posterior_t   posterior_q[$];

    int  items_queued = 0;
    int  items_sent = 0;
    int  posteriors_seen = 0;
    int  mismatches = 0;
    int  sets_closed = 0;
    int  rx_hold = 0;           // long receiver hold-off, set by the sequencer
    bit  hold_send = 0;
    bit  idle_on = 1;           // cleared for stretches without any gaps
    bit  offering = 0;
    longint cycles = 0;

    // posterior of the set closed by this item, from the priors held now
    function automatic posterior_t close_set();
        posterior_t r;
        longint n, lq, mq, den, num, mean_v, d;
        longint unsigned shp, stg, us, ud, ss;
        logic [127:0] w, rate_w;
        bit sat;
        sat = set_dropped;
        n = set_count;
        r.count = set_count[10:0];
        if (n == 0) begin
            r.mean = mu0;
            r.shape = alpha0;
            r.rate = {16'd0, beta0};
            r.strength = lambda0;
        end else begin
            lq = {32'd0, lambda0};
            mq = longint'(mu0);
            den = n * 65536 + lq;
            num = lq * mq + set_sum * 65536;
            mean_v = num / den;
            if (mean_v > 8388607) begin
                mean_v = 8388607;
                sat = 1;
            end
            if (mean_v < -8388608) begin
                mean_v = -8388608;
                sat = 1;
            end
            r.mean = mean_v[23:0];
            shp = {32'd0, alpha0} + n * 32768;
            if (shp > 64'hFFFF_FFFF) begin
                shp = 64'hFFFF_FFFF;
                sat = 1;
            end
            r.shape = shp[31:0];
            stg = lq + n * 65536;
            if (stg > 64'hFFFF_FFFF) begin
                stg = 64'hFFFF_FFFF;
                sat = 1;
            end
            r.strength = stg[31:0];
            // squared deviations: sumsq - floor(sum^2 / n), floored at zero
            us = (set_sum < 0) ? -set_sum : set_sum;
            w = (128'(us) * 128'(us)) / 128'(n);
            ss = (w > 128'(set_sumsq)) ? 0 : set_sumsq - w[63:0];
            // prior pull term, floored stage by stage
            d = set_sum - n * mq;
            ud = (d < 0) ? -d : d;
            w = 128'(ud) * 128'(ud) * 128'(lq);
            w = w / 128'(n);
            w = w / 128'(den);
            w = w >> 17;
            if (w > 128'(nig_pkg::RATE_MAX)) begin
                rate_w = 128'(nig_pkg::RATE_MAX);
                sat = 1;
            end else begin
                rate_w = 128'(beta0) + 128'(ss >> 17) + w;
                if (rate_w > 128'(nig_pkg::RATE_MAX)) begin
                    rate_w = 128'(nig_pkg::RATE_MAX);
                    sat = 1;
                end
            end
            r.rate = rate_w[47:0];
        end
        r.ovf = sat;
        return r;
    endfunction

    function automatic void absorb_item(sample_item_t it);
        longint s;
        if (it.has_sample) begin
            if (set_count < CAPACITY) begin
                s = longint'($signed(it.sample));
                set_sum += s;
                set_sumsq += longint'(s * s);
                set_count++;
            end else begin
                set_dropped = 1;
            end
        end
        if (it.last) begin
            posterior_q.push_back(close_set());
            sets_closed++;
            set_sum = 0;
            set_sumsq = 0;
            set_count = 0;
            set_dropped = 0;
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: one item register, reloaded from the pending queue
    sample_item_t cur_item = '0;
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(cur_item);
                items_sent++;
                offering = 0;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() > 0 && !hold_send) begin
                    cur_item = pending_items.pop_front();
                    offering = 1;
                    tx_gap = pick_gap();
                end
            end
            s_valid      <= offering;
            s_sample     <= cur_item.sample;
            s_has_sample <= cur_item.has_sample;
            s_last       <= cur_item.last;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge aclk) begin
        if (rx_hold > 0)
            rx_hold--;
    end

    // monitor: checks posteriors and plays the receiver's stalls
    int rx_stall = 0;
    always @(posedge aclk) begin
        posterior_t got, want;
        logic rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_post_mean, m_post_shape, m_post_rate, m_post_strength,
                       m_sample_count, m_overflow};
                posteriors_seen++;
                if (posterior_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected posterior item: %h", got);
                end else begin
                    want = posterior_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"posterior mismatch: exp mean %h shape %h rate %h ",
                                      "str %h cnt %0d ovf %b / got mean %h shape %h ",
                                      "rate %h str %h cnt %0d ovf %b"},
                                     want.mean, want.shape, want.rate, want.strength,
                                     want.count, want.ovf, got.mean, got.shape,
                                     got.rate, got.strength, got.count, got.ovf);
                    end
                end
            end
            if (rx_hold > 0) begin
                rdy = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                rx_stall = pick_gap();
            end
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_prior(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            nig_pkg::CFG_PRIOR_MEAN:     mu0 = val[23:0];
            nig_pkg::CFG_PRIOR_SHAPE:    alpha0 = val;
            nig_pkg::CFG_PRIOR_RATE:     beta0 = val;
            nig_pkg::CFG_PRIOR_STRENGTH: lambda0 = val;
            default: ;
        endcase
    endtask

    task automatic write_priors(input logic [31:0] m, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] l);
        write_prior(nig_pkg::CFG_PRIOR_MEAN, m);
        write_prior(nig_pkg::CFG_PRIOR_SHAPE, a);
        write_prior(nig_pkg::CFG_PRIOR_RATE, b);
        write_prior(nig_pkg::CFG_PRIOR_STRENGTH, l);
    endtask

    // wait until nothing is in flight, then past the longest close
    task automatic drain();
        while (pending_items.size() > 0 || offering || posterior_q.size() > 0)
            @(posedge aclk);
        repeat (CLOSE_WAIT) @(posedge aclk);
    endtask

    task automatic push_item(input logic [23:0] smp, input bit has, input bit lst);
        pending_items.push_back('{smp, has, lst});
        items_queued++;
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return nig_pkg::MEAN_POS_MAX;
            1:       return nig_pkg::MEAN_NEG_MIN;
            2, 3:    return 24'($signed($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    // one well-formed set; noise items and a sample-less close now and then
    task automatic push_set(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                push_item(24'($urandom), 1'b0, 1'b0);
            push_item(rand_sample(), 1'b1, (i == n - 1) && $urandom_range(0, 4) != 0);
        end
        if (n == 0 || !pending_items[$].last)
            push_item(24'($urandom), 1'b0, 1'b1);
    endtask

    function automatic logic [31:0] rand_prior();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return nig_pkg::U32_MAX;
            2:       return 32'($urandom_range(1, 8)) << 16;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default priors: empty set, ignored item, extremes, single samples
        push_item(24'h0, 1'b0, 1'b1);
        push_item(24'h123456, 1'b0, 1'b0);
        push_item(nig_pkg::MEAN_POS_MAX, 1'b1, 1'b1);
        push_item(nig_pkg::MEAN_NEG_MIN, 1'b1, 1'b1);
        push_item(nig_pkg::MEAN_POS_MAX, 1'b1, 1'b0);
        push_item(nig_pkg::MEAN_POS_MAX, 1'b1, 1'b0);
        push_item(nig_pkg::MEAN_NEG_MIN, 1'b1, 1'b1);
        push_item(24'h000000, 1'b1, 1'b0);
        push_item(24'hFFFFFF, 1'b1, 1'b0);
        push_item(24'h010000, 1'b0, 1'b1);
        drain();

        // extreme priors: saturating shape and strength, zero strength
        write_priors(32'h0080_0000, nig_pkg::U32_MAX, nig_pkg::U32_MAX, nig_pkg::U32_MAX);
        push_item(nig_pkg::MEAN_POS_MAX, 1'b1, 1'b0);
        push_item(24'h7F0000, 1'b1, 1'b1);
        push_item(24'h0, 1'b0, 1'b1);
        drain();
        write_priors(32'h007F_FFFF, 32'd0, 32'd0, 32'd0);
        push_item(nig_pkg::MEAN_NEG_MIN, 1'b1, 1'b1);
        push_item(24'h000001, 1'b1, 1'b0);
        push_item(24'hFFFFFF, 1'b1, 1'b1);
        push_item(24'h0, 1'b0, 1'b1);
        drain();

        // overfilled set: samples past capacity are dropped and flagged
        write_priors($urandom, $urandom, $urandom, 32'h0001_0000);
        for (int i = 0; i < CAPACITY + 6; i++)
            push_item(rand_sample(), 1'b1, i == CAPACITY + 5);
        push_item(24'h0, 1'b1, 1'b1);
        drain();

        // receiver holds off long while the sender keeps streaming sets
        rx_hold = 4000;
        for (int k = 0; k < 12; k++)
            push_set($urandom_range(1, 4));
        drain();

        // random phases, each with fresh priors
        while (items_queued < ITEM_TARGET) begin
            write_priors(rand_prior(), rand_prior(), rand_prior(), rand_prior());
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 10; k++) begin
                n = ($urandom_range(0, 19) == 0) ? 0 :
                    ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300) :
                    $urandom_range(1, 12);
                push_set(n);
            end
            // sender pauses until every posterior is back
            if ($urandom_range(0, 2) == 0) begin
                while (pending_items.size() > 0 || offering)
                    @(posedge aclk);
                hold_send = 1;
                while (posterior_q.size() > 0)
                    @(posedge aclk);
                hold_send = 0;
            end
            drain();
        end

        drain();
        $display("sent %0d sample items over %0d sets, checked %0d posteriors",
                 items_sent, sets_closed, posteriors_seen);
        $display("priors swept through defaults, zero, full-scale and random values");
        if (mismatches == 0 && posterior_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d posteriors never seen",
                     mismatches, posterior_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
